// ===== sv/edts_pkg.sv =====
// Package for the encoder date/time setter: request types, codes and calendar helpers.
`default_nettype none

package edts_pkg;

  // Default width of the stored millisecond timestamps.
  localparam int STAMP_BITS_DEFAULT = 32;

  // Configuration port geometry.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLED        = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DOUBLE_WINDOW  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_HOLD      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_YEAR_LOWEST    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_YEAR_HIGHEST   = 3'd4;

  // Selectable fields.
  localparam logic [2:0] FIELD_YEAR   = 3'd0;
  localparam logic [2:0] FIELD_MONTH  = 3'd1;
  localparam logic [2:0] FIELD_DAY    = 3'd2;
  localparam logic [2:0] FIELD_HOUR   = 3'd3;
  localparam logic [2:0] FIELD_MINUTE = 3'd4;
  localparam logic [2:0] FIELD_LAST   = FIELD_MINUTE;

  // Reset values of configuration and calendar state.
  localparam logic [15:0] DOUBLE_WINDOW_RESET = 16'd450;
  localparam logic [15:0] LONG_HOLD_RESET     = 16'd800;
  localparam logic [11:0] YEAR_LOWEST_RESET   = 12'd2020;
  localparam logic [11:0] YEAR_HIGHEST_RESET  = 12'd2037;
  localparam logic [11:0] YEAR_RESET          = 12'd2026;
  localparam logic [3:0]  MONTH_RESET         = 4'd1;
  localparam logic [4:0]  DAY_RESET           = 5'd1;
  localparam logic [4:0]  HOUR_RESET          = 5'd12;
  localparam logic [5:0]  MINUTE_RESET        = 6'd0;

  // Field bounds.
  localparam logic [3:0] MONTH_MIN  = 4'd1;
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [3:0] MONTH_FEB  = 4'd2;
  localparam logic [4:0] DAY_MIN    = 5'd1;
  localparam logic [4:0] DAYS_LONG  = 5'd31;
  localparam logic [4:0] DAYS_LEAP  = 5'd29;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;

  // floor(y / 25) equals (y * RECIP_25) >> 15 for every 12-bit y.
  localparam logic [10:0] RECIP_25 = 11'd1311;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [1:0] {
    EVT_NONE   = 2'd0,
    EVT_CANCEL = 2'd1,
    EVT_SAVE   = 2'd2
  } evt_code_t;

  typedef struct packed {
    logic signed [1:0] rotate_step;
    logic              button_down;
    logic [31:0]       now_ms;
  } in_item_t;

  typedef struct packed {
    evt_code_t   event_code;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [2:0]  selected_out;
  } out_item_t;

  // Gregorian leap rule. Divisible by 100 is divisible by 4 and by 25;
  // divisible by 400 is divisible by 16 and by 25.
  function automatic logic leap_year(input logic [11:0] y);
    logic [22:0] prod;
    logic [7:0]  quot;
    logic [12:0] back;
    logic        div25;
    prod  = 23'(y) * 23'(RECIP_25);
    quot  = prod[22:15];
    back  = 13'(quot) * 13'd25;
    div25 = (back == {1'b0, y});
    return ((y[1:0] == 2'b00) && !div25) || ((y[3:0] == 4'b0000) && div25);
  endfunction

  function automatic logic [4:0] month_days(input logic [11:0] y, input logic [3:0] m);
    logic [3:0] idx;
    idx = m - 4'd1;
    if (m < MONTH_MIN || m > MONTH_MAX) begin
      return DAYS_LONG;
    end else if (m == MONTH_FEB && leap_year(y)) begin
      return DAYS_LEAP;
    end
    return MONTH_LEN[idx];
  endfunction

  function automatic logic [4:0] fix_day(input logic [4:0] d, input logic [4:0] top);
    logic [4:0] v;
    v = (d > top) ? top : d;
    return (v < DAY_MIN) ? DAY_MIN : v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/encoder_date_time_setter.sv =====
// Top level of the rotary-encoder date/time setter.
`default_nettype none

// The block takes one encoder poll sample per request (step sign, button level and a
// millisecond timestamp) and answers every request with exactly one result: an event
// code (none, cancel or save) and the current year, month, day, hour, minute and
// selected field. A step moves the selected field up or down and wraps at its bounds;
// the day is bounded by a leap-aware month length and is clamped whenever the year or
// the month moves. A release advances the selection, a second release inside the
// double window signals cancel, and holding the button for the long-hold time signals
// save once per press. A request is accepted in every cycle in which the result
// register is empty or its result is being taken, so the block sustains one sample per
// clock; its result is written into the result register at the edge that accepts it. The
// calendar and press-timing state is updated at the same edge as the result register,
// so each sample sees the effect of the one before it. Configuration writes take
// effect at the next edge and are meant to happen only while no request is in flight.
// Timestamps are kept to STAMP_BITS bits and compared through modular differences.
module encoder_date_time_setter
  import edts_pkg::*;
#(
  parameter int STAMP_BITS = STAMP_BITS_DEFAULT
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output out_item_t                out_data,
  input  wire                      cfg_write,
  input  wire [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire [CFG_DATA_BITS-1:0]  cfg_data
);

  // Configuration registers.
  logic        enabled;
  logic [15:0] double_window_ms;
  logic [15:0] long_hold_ms;
  logic [11:0] year_lowest;
  logic [11:0] year_highest;

  // Calendar and press-timing state.
  logic [11:0]           year_reg;
  logic [3:0]            month_reg;
  logic [4:0]            day_reg;
  logic [4:0]            hour_reg;
  logic [5:0]            minute_reg;
  logic [2:0]            cur_field;
  logic                  held_flag;
  logic [STAMP_BITS-1:0] hold_start;
  logic                  long_done;
  logic [STAMP_BITS-1:0] last_release;

  // Next values of the state, already gated by the enable.
  logic [11:0]           year_reg_next;
  logic [3:0]            month_reg_next;
  logic [4:0]            day_reg_next;
  logic [4:0]            hour_reg_next;
  logic [5:0]            minute_reg_next;
  logic [2:0]            cur_field_next;
  logic                  held_flag_next;
  logic [STAMP_BITS-1:0] hold_start_next;
  logic                  long_done_next;
  logic [STAMP_BITS-1:0] last_release_next;
  evt_code_t             evt_next;

  // Intermediate values of the rotation phase.
  logic                  in_accept;
  logic                  step_any;
  logic                  step_up;
  logic [11:0]           year_step;
  logic [3:0]            month_step;
  logic [4:0]            day_step;
  logic [4:0]            hour_step;
  logic [5:0]            minute_step;
  logic [4:0]            top_days;
  logic [2:0]            sel_inc;

  // Timestamp handling: the 32-bit sample is masked or zero-extended to STAMP_BITS.
  logic [STAMP_BITS+31:0] now_wide;
  logic [STAMP_BITS-1:0]  now_s;
  logic [STAMP_BITS-1:0]  release_gap;
  logic [STAMP_BITS-1:0]  hold_gap;
  logic                   release_is_double;
  logic                   hold_is_long;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // Any nonzero step code moves the field; only plus one moves it up.
  assign step_any = (in_data.rotate_step != 2'sd0);
  assign step_up  = (in_data.rotate_step == 2'sd1);

  assign now_wide = {{STAMP_BITS{1'b0}}, in_data.now_ms};
  assign now_s    = now_wide[STAMP_BITS-1:0];

  assign release_gap = now_s - last_release;
  assign hold_gap    = now_s - hold_start;

  // Both sides are widened so that the 16-bit thresholds compare at any stamp width.
  assign release_is_double = ({16'd0, release_gap} <
                              {{STAMP_BITS{1'b0}}, double_window_ms});
  assign hold_is_long      = ({16'd0, hold_gap} >=
                              {{STAMP_BITS{1'b0}}, long_hold_ms});

  // Rotation phase for everything but the day.
  always_comb begin
    year_step   = year_reg;
    month_step  = month_reg;
    hour_step   = hour_reg;
    minute_step = minute_reg;
    if (step_any) begin
      unique case (cur_field)
        FIELD_YEAR: begin
          if (step_up) begin
            year_step = (year_reg >= year_highest) ? year_lowest : year_reg + 12'd1;
          end else begin
            year_step = (year_reg <= year_lowest) ? year_highest : year_reg - 12'd1;
          end
        end
        FIELD_MONTH: begin
          if (step_up) begin
            month_step = (month_reg >= MONTH_MAX) ? MONTH_MIN : month_reg + 4'd1;
          end else begin
            month_step = (month_reg <= MONTH_MIN) ? MONTH_MAX : month_reg - 4'd1;
          end
        end
        FIELD_HOUR: begin
          if (step_up) begin
            hour_step = (hour_reg >= HOUR_MAX) ? 5'd0 : hour_reg + 5'd1;
          end else begin
            hour_step = (hour_reg == 5'd0) ? HOUR_MAX : hour_reg - 5'd1;
          end
        end
        FIELD_MINUTE: begin
          if (step_up) begin
            minute_step = (minute_reg >= MINUTE_MAX) ? 6'd0 : minute_reg + 6'd1;
          end else begin
            minute_step = (minute_reg == 6'd0) ? MINUTE_MAX : minute_reg - 6'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Month length after the rotation. When the day itself is stepped the year and
  // month are unchanged, so the same length bounds the day roll.
  assign top_days = month_days(year_step, month_step);

  always_comb begin
    day_step = day_reg;
    if (step_any) begin
      if (cur_field == FIELD_YEAR || cur_field == FIELD_MONTH) begin
        day_step = fix_day(day_reg, top_days);
      end else if (cur_field == FIELD_DAY) begin
        if (step_up) begin
          day_step = (day_reg >= top_days) ? DAY_MIN : day_reg + 5'd1;
        end else begin
          day_step = (day_reg <= DAY_MIN) ? top_days : day_reg - 5'd1;
        end
      end
    end
  end

  // The selection wraps to the year after the minute, and from any unused code.
  assign sel_inc = (cur_field >= FIELD_LAST) ? FIELD_YEAR : cur_field + 3'd1;

  // Button phase, then the enable gate.
  always_comb begin
    year_reg_next     = year_step;
    month_reg_next    = month_step;
    day_reg_next      = day_step;
    hour_reg_next     = hour_step;
    minute_reg_next   = minute_step;
    cur_field_next    = cur_field;
    held_flag_next    = held_flag;
    hold_start_next   = hold_start;
    long_done_next    = long_done;
    last_release_next = last_release;
    evt_next          = EVT_NONE;

    priority if (in_data.button_down && !held_flag) begin
      // Press edge starts the hold timer.
      held_flag_next  = 1'b1;
      hold_start_next = now_s;
      long_done_next  = 1'b0;
    end else if (!in_data.button_down && held_flag) begin
      held_flag_next = 1'b0;
      priority if (long_done) begin
        // Release after a save is not remembered for double-press detection.
        last_release_next = '0;
      end else if (last_release != '0 && release_is_double) begin
        last_release_next = '0;
        evt_next          = EVT_CANCEL;
      end else begin
        cur_field_next    = sel_inc;
        last_release_next = now_s;
      end
    end else if (in_data.button_down && held_flag && !long_done && hold_is_long) begin
      long_done_next = 1'b1;
      day_reg_next   = fix_day(day_step, top_days);
      evt_next       = EVT_SAVE;
    end else begin
    end

    if (!enabled) begin
      year_reg_next     = year_reg;
      month_reg_next    = month_reg;
      day_reg_next      = day_reg;
      hour_reg_next     = hour_reg;
      minute_reg_next   = minute_reg;
      cur_field_next    = cur_field;
      held_flag_next    = held_flag;
      hold_start_next   = hold_start;
      long_done_next    = long_done;
      last_release_next = last_release;
      evt_next          = EVT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled          <= 1'b1;
      double_window_ms <= DOUBLE_WINDOW_RESET;
      long_hold_ms     <= LONG_HOLD_RESET;
      year_lowest      <= YEAR_LOWEST_RESET;
      year_highest     <= YEAR_HIGHEST_RESET;
      year_reg         <= YEAR_RESET;
      month_reg        <= MONTH_RESET;
      day_reg          <= DAY_RESET;
      hour_reg         <= HOUR_RESET;
      minute_reg       <= MINUTE_RESET;
      cur_field        <= FIELD_YEAR;
      held_flag        <= 1'b0;
      hold_start       <= '0;
      long_done        <= 1'b0;
      last_release     <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_ENABLED:       enabled          <= cfg_data[0];
          CFG_DOUBLE_WINDOW: double_window_ms <= cfg_data;
          CFG_LONG_HOLD:     long_hold_ms     <= cfg_data;
          CFG_YEAR_LOWEST:   year_lowest      <= cfg_data[11:0];
          CFG_YEAR_HIGHEST:  year_highest     <= cfg_data[11:0];
          default: begin
          end
        endcase
      end

      if (in_accept) begin
        year_reg     <= year_reg_next;
        month_reg    <= month_reg_next;
        day_reg      <= day_reg_next;
        hour_reg     <= hour_reg_next;
        minute_reg   <= minute_reg_next;
        cur_field    <= cur_field_next;
        held_flag    <= held_flag_next;
        hold_start   <= hold_start_next;
        long_done    <= long_done_next;
        last_release <= last_release_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register; its contents matter only while out_valid is high.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data.event_code   <= evt_next;
      out_data.year_out     <= year_reg_next;
      out_data.month_out    <= month_reg_next;
      out_data.day_out      <= day_reg_next;
      out_data.hour_out     <= hour_reg_next;
      out_data.minute_out   <= minute_reg_next;
      out_data.selected_out <= cur_field_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/encoder_date_time_setter_test.sv =====
// Testbench for the encoder date/time setter: calendar scoreboard, request drivers and checks.
`timescale 1ns / 1ps

// Every request into the block is one encoder poll, and every poll answers with exactly one
// readout. A scoreboard object keeps its own copy of the configuration and of the calendar
// and press-timing state. It works out the expected readout of each poll at the clock edge
// where the poll is accepted, and checks each accepted readout against the oldest one waiting.
//
// The stimulus opens with a short directed run under the reset configuration: wraps of the
// month and the minute, a cancel just inside the double window and a release exactly on its
// edge, a save exactly on the long-hold threshold with no second save, a release at time
// zero and a timestamp wrap. After that come phases that each start from an idle block with
// a new configuration. The phases use the extreme windows, inverted and extreme year bounds,
// a disabled block and year ranges around leap centuries. Most random polls are built into
// gestures (turns, clicks, double clicks and long holds) whose timing lands around the
// configured thresholds. The rest is noise with random levels and timestamps.
module encoder_date_time_setter_test;
  import edts_pkg::*;

  localparam time_unit_half = 10;
  localparam int RESET_CYCLES = 11;
  // The longest stretch without any request moving is the receiver hold-off below.
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES = 11;
  localparam int POLLS_PER_PHASE = 120;
  localparam int POLLS_DISABLED = 40;

  localparam logic signed [1:0] STEP_NONE = 2'sd0;
  localparam logic signed [1:0] STEP_UP   = 2'sd1;
  localparam logic signed [1:0] STEP_DOWN = -2'sd1;

  // Expected behavior of the block, kept in step with every accepted poll.
  class setter_scoreboard;
    bit        enabled;
    bit [15:0] double_window;
    bit [15:0] long_hold;
    bit [11:0] year_lo;
    bit [11:0] year_hi;

    bit [11:0] year;
    bit [3:0]  month;
    bit [4:0]  day;
    bit [4:0]  hour;
    bit [5:0]  minute;
    bit [2:0]  field;
    bit        held;
    bit        long_done;
    bit [31:0] hold_start;
    bit [31:0] last_release;

    out_item_t expected_readouts[$];
    int        errors;

    function new();
      enabled       = 1'b1;
      double_window = DOUBLE_WINDOW_RESET;
      long_hold     = LONG_HOLD_RESET;
      year_lo       = YEAR_LOWEST_RESET;
      year_hi       = YEAR_HIGHEST_RESET;
      year          = YEAR_RESET;
      month         = MONTH_RESET;
      day           = DAY_RESET;
      hour          = HOUR_RESET;
      minute        = MINUTE_RESET;
      field         = FIELD_YEAR;
      held          = 1'b0;
      long_done     = 1'b0;
      hold_start    = '0;
      last_release  = '0;
      errors        = 0;
    endfunction

    function void set_register(bit [CFG_INDEX_BITS-1:0] idx, bit [CFG_DATA_BITS-1:0] value);
      case (idx)
        CFG_ENABLED:       enabled = value[0];
        CFG_DOUBLE_WINDOW: double_window = value;
        CFG_LONG_HOLD:     long_hold = value;
        CFG_YEAR_LOWEST:   year_lo = value[11:0];
        CFG_YEAR_HIGHEST:  year_hi = value[11:0];
        default: ;
      endcase
    endfunction

    function bit is_leap(bit [11:0] y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function bit [4:0] month_length(bit [11:0] y, bit [3:0] m);
      if (m < MONTH_MIN || m > MONTH_MAX) return DAYS_LONG;
      if (m == MONTH_FEB && is_leap(y)) return DAYS_LEAP;
      return MONTH_LEN[m - 1];
    endfunction

    function void limit_day();
      bit [4:0] top;
      top = month_length(year, month);
      if (day > top) day = top;
      if (day < DAY_MIN) day = DAY_MIN;
    endfunction

    function int unsigned roll_value(int unsigned v, int unsigned lo, int unsigned hi, bit up);
      if (up) return (v >= hi) ? lo : v + 1;
      return (v <= lo) ? hi : v - 1;
    endfunction

    function void turn_knob(bit up);
      case (field)
        FIELD_YEAR: begin
          year = 12'(roll_value(year, year_lo, year_hi, up));
          limit_day();
        end
        FIELD_MONTH: begin
          month = 4'(roll_value(month, MONTH_MIN, MONTH_MAX, up));
          limit_day();
        end
        FIELD_DAY:    day = 5'(roll_value(day, DAY_MIN, month_length(year, month), up));
        FIELD_HOUR:   hour = 5'(roll_value(hour, 0, HOUR_MAX, up));
        FIELD_MINUTE: minute = 6'(roll_value(minute, 0, MINUTE_MAX, up));
        default: ;
      endcase
    endfunction

    // The rotation is applied first, then the button level is looked at.
    function void take_poll(in_item_t p);
      out_item_t r;
      evt_code_t code;
      bit [31:0] since_release;
      bit [31:0] held_for;
      code = EVT_NONE;
      if (enabled) begin
        if (p.rotate_step != STEP_NONE) turn_knob(p.rotate_step == STEP_UP);
        since_release = p.now_ms - last_release;
        held_for      = p.now_ms - hold_start;
        if (p.button_down && !held) begin
          held       = 1'b1;
          hold_start = p.now_ms;
          long_done  = 1'b0;
        end else if (!p.button_down && held) begin
          held = 1'b0;
          if (long_done) begin
            // The release that ends a save press is not remembered.
            last_release = '0;
          end else if (last_release != 0 && since_release < 32'(double_window)) begin
            last_release = '0;
            code = EVT_CANCEL;
          end else begin
            field = (field >= FIELD_LAST) ? FIELD_YEAR : field + 3'd1;
            last_release = p.now_ms;
          end
        end else if (p.button_down && held && !long_done && held_for >= 32'(long_hold)) begin
          long_done = 1'b1;
          limit_day();
          code = EVT_SAVE;
        end
      end
      r.event_code   = code;
      r.year_out     = year;
      r.month_out    = month;
      r.day_out      = day;
      r.hour_out     = hour;
      r.minute_out   = minute;
      r.selected_out = field;
      expected_readouts.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("ERROR: %s", msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task check_readout(out_item_t got);
      out_item_t want;
      if (expected_readouts.size() == 0) begin
        report($sformatf("readout %h arrived with no poll waiting", got));
        return;
      end
      want = expected_readouts.pop_front();
      compare_field("event_code", got.event_code, want.event_code);
      compare_field("year_out", got.year_out, want.year_out);
      compare_field("month_out", got.month_out, want.month_out);
      compare_field("day_out", got.day_out, want.day_out);
      compare_field("hour_out", got.hour_out, want.hour_out);
      compare_field("minute_out", got.minute_out, want.minute_out);
      compare_field("selected_out", got.selected_out, want.selected_out);
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  in_item_t                  in_data = '0;
  logic                      out_valid;
  logic                      out_ready;
  out_item_t                 out_data;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  setter_scoreboard sb = new();

  // Idling profile of the current phase, in percent of cycles.
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_wanted = 1'b0;
  logic [31:0] clock_ms = '0;
  int          polls_sent = 0;
  int          quiet_cycles = 0;

  encoder_date_time_setter dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(time_unit_half) clk = ~clk;

  // Everything is sampled at the rising edge, before any nonblocking update of that edge,
  // so both the block and the testbench see the values that the edge itself captures.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.take_poll(in_data);
      if (out_valid && out_ready) sb.check_readout(out_data);
    end
  end

  // The run is stopped if no request moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("encoder_date_time_setter test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver. On request it holds off for a long stretch so that the result register fills
  // and the block has to refuse polls while the sender keeps offering them.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic signed [1:0] rand_step();
    case ($urandom_range(3))
      0: return STEP_UP;
      1: return STEP_DOWN;
      default: return STEP_NONE;
    endcase
  endfunction

  // A time offset that often hits a threshold exactly or one off, and otherwise falls on
  // either side of it.
  function automatic logic [31:0] gap_around(logic [31:0] mark);
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 2) return mark;
    if (pick == 2) return (mark == 0) ? mark : mark - 1;
    if (pick == 3) return mark + 1;
    if (pick < 7) return $urandom_range(mark);
    return mark + $urandom_range(mark + 16);
  endfunction

  // Offers one poll and returns at the edge where it is accepted. It is always entered in
  // a time step right after a rising edge; valid drops between polls only for idle gaps.
  task automatic send_poll(logic signed [1:0] step, logic btn, logic [31:0] stamp);
    in_item_t req;
    req.rotate_step = step;
    req.button_down = btn;
    req.now_ms      = stamp;
    clock_ms = stamp;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    polls_sent++;
  endtask

  // Registers are only written while nothing is in flight.
  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  // Waits until every readout that was predicted has been taken and checked.
  task automatic wait_drained();
    do @(posedge clk); while (sb.expected_readouts.size() != 0);
  endtask

  // One user gesture, with its timing placed around the configured thresholds.
  task automatic play_gesture();
    int unsigned pick;
    int unsigned n;
    logic [31:0] win;
    logic [31:0] hold;
    logic [31:0] start;
    logic [31:0] span;
    logic [31:0] stamp;
    win  = 32'(sb.double_window);
    hold = 32'(sb.long_hold);
    pick = $urandom_range(99);
    if (pick < 20) begin
      // Turning the knob with the button up.
      n = $urandom_range(1, 4);
      repeat (n) send_poll(rand_step(), 1'b0, clock_ms + $urandom_range(60));
    end else if (pick < 45) begin
      // A single click that starts around the double window after the last release.
      send_poll(rand_step(), 1'b1, clock_ms + gap_around(win));
      repeat ($urandom_range(2)) send_poll(rand_step(), 1'b1, clock_ms + $urandom_range(hold / 3));
      send_poll(rand_step(), 1'b0, clock_ms + $urandom_range(hold / 3 + 1));
    end else if (pick < 65) begin
      // A double click: the second release lands around the edge of the double window.
      send_poll(rand_step(), 1'b1, clock_ms + win + $urandom_range(win));
      send_poll(rand_step(), 1'b0, clock_ms + $urandom_range(hold / 2));
      start = clock_ms;
      span  = gap_around(win);
      send_poll(rand_step(), 1'b1, start + span / 2);
      send_poll(rand_step(), 1'b0, start + span);
    end else if (pick < 85) begin
      // A long hold that crosses the save threshold or just misses it, then more held polls
      // that must not save again.
      start = clock_ms + $urandom_range(win + hold);
      send_poll(rand_step(), 1'b1, start);
      span = gap_around(hold);
      n = $urandom_range(1, 3);
      for (int i = 1; i <= n; i++) send_poll(rand_step(), 1'b1, start + span * i / n);
      repeat ($urandom_range(2)) send_poll(rand_step(), 1'b1, clock_ms + $urandom_range(100));
      send_poll(rand_step(), 1'b0, clock_ms + $urandom_range(100));
    end else begin
      // Noise: random levels with random, wrapping or nearby timestamps.
      n = $urandom_range(1, 3);
      repeat (n) begin
        pick = $urandom_range(9);
        if (pick < 3) stamp = $urandom();
        else if (pick < 5) stamp = 32'hFFFF_FFFF - $urandom_range(3000);
        else stamp = clock_ms + $urandom_range(2000);
        send_poll(rand_step(), 1'($urandom_range(1)), stamp);
      end
    end
  endtask

  initial begin
    int          phase;
    int          quota;
    int          phase_start;
    logic [11:0] lo;
    logic [11:0] hi;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed run under the reset configuration, starting with the year selected.
    send_poll(STEP_NONE, 1'b0, 32'd0);
    send_poll(STEP_DOWN, 1'b0, 32'd10);
    send_poll(STEP_UP, 1'b0, 32'd20);
    // A click moves the selection to the month, which then wraps both ways.
    send_poll(STEP_NONE, 1'b1, 32'd100);
    send_poll(STEP_NONE, 1'b0, 32'd200);
    send_poll(STEP_DOWN, 1'b0, 32'd210);
    send_poll(STEP_UP, 1'b0, 32'd220);
    // The second release comes one millisecond inside the double window: cancel.
    send_poll(STEP_NONE, 1'b1, 32'd500);
    send_poll(STEP_NONE, 1'b0, 32'd649);
    // Held one short of the threshold, then exactly on it: one save and no second one.
    send_poll(STEP_NONE, 1'b1, 32'd1000);
    send_poll(STEP_UP, 1'b1, 32'd1799);
    send_poll(STEP_NONE, 1'b1, 32'd1800);
    send_poll(STEP_NONE, 1'b1, 32'd9000);
    send_poll(STEP_NONE, 1'b0, 32'd9001);
    // After a save release nothing is remembered, so this click advances to the day.
    send_poll(STEP_NONE, 1'b1, 32'd9100);
    send_poll(STEP_NONE, 1'b0, 32'd9550);
    // A press just before the timestamp wraps and a release at time zero.
    send_poll(STEP_NONE, 1'b1, 32'hFFFF_FFF0);
    send_poll(STEP_NONE, 1'b0, 32'd0);
    // A release at zero is not remembered, so a quick click still advances.
    send_poll(STEP_NONE, 1'b1, 32'd5);
    send_poll(STEP_NONE, 1'b0, 32'd10);
    send_poll(STEP_DOWN, 1'b0, 32'hFFFF_FFFF);
    send_poll(STEP_UP, 1'b0, 32'hFFFF_FFFF);
    // A release exactly one window after the last one is not a cancel.
    send_poll(STEP_NONE, 1'b1, 32'd400);
    send_poll(STEP_NONE, 1'b0, 32'd460);
    in_valid <= 1'b0;
    wait_drained();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      quota = POLLS_PER_PHASE;
      case (phase)
        0: begin
          write_reg(CFG_ENABLED, 16'd1);
          write_reg(CFG_DOUBLE_WINDOW, DOUBLE_WINDOW_RESET);
          write_reg(CFG_LONG_HOLD, LONG_HOLD_RESET);
          write_reg(CFG_YEAR_LOWEST, 16'(YEAR_LOWEST_RESET));
          write_reg(CFG_YEAR_HIGHEST, 16'(YEAR_HIGHEST_RESET));
        end
        1: begin
          // No cancel is possible, and a save fires on the first held poll after the press.
          write_reg(CFG_DOUBLE_WINDOW, 16'd0);
          write_reg(CFG_LONG_HOLD, 16'd0);
          write_reg(CFG_YEAR_LOWEST, 16'd0);
          write_reg(CFG_YEAR_HIGHEST, 16'hF000 | 16'd4095);
        end
        2: begin
          // Widest windows and inverted year bounds.
          write_reg(CFG_DOUBLE_WINDOW, 16'hFFFF);
          write_reg(CFG_LONG_HOLD, 16'hFFFF);
          write_reg(CFG_YEAR_LOWEST, 16'd3000);
          write_reg(CFG_YEAR_HIGHEST, 16'd100);
        end
        3: begin
          // Disabled: every poll shows the held state and no event.
          write_reg(CFG_ENABLED, {15'($urandom()), 1'b0});
          quota = POLLS_DISABLED;
        end
        4: begin
          write_reg(CFG_ENABLED, {15'($urandom()), 1'b1});
          write_reg(CFG_DOUBLE_WINDOW, 16'd1);
          write_reg(CFG_LONG_HOLD, 16'd1);
          write_reg(CFG_YEAR_LOWEST, 16'd4090);
          write_reg(CFG_YEAR_HIGHEST, 16'd4095);
        end
        default: begin
          // Year ranges around leap centuries, or anywhere at all.
          case ($urandom_range(6))
            0: lo = 12'd0;
            1: lo = 12'd1896;
            2: lo = 12'd1996;
            3: lo = 12'd2096;
            4: lo = 12'd2396;
            5: lo = 12'd3996;
            default: lo = 12'($urandom());
          endcase
          hi = lo + 12'($urandom_range(4, 12));
          if ($urandom_range(4) == 0) begin
            write_reg(CFG_YEAR_LOWEST, {4'($urandom()), hi});
            write_reg(CFG_YEAR_HIGHEST, {4'($urandom()), lo});
          end else begin
            write_reg(CFG_YEAR_LOWEST, {4'($urandom()), lo});
            write_reg(CFG_YEAR_HIGHEST, {4'($urandom()), hi});
          end
          write_reg(CFG_DOUBLE_WINDOW, 16'($urandom_range(1, 1200)));
          write_reg(CFG_LONG_HOLD, 16'($urandom_range(1, 1500)));
        end
      endcase
      if (phase == 5) hold_wanted = 1'b1;
      phase_start = polls_sent;
      while (polls_sent - phase_start < quota) play_gesture();
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_readouts.size() != 0) begin
      sb.report($sformatf("%0d readouts never arrived", sb.expected_readouts.size()));
    end
    if (sb.errors == 0) begin
      $display("encoder_date_time_setter test passed");
    end else begin
      $display("encoder_date_time_setter test failed");
    end
    $finish;
  end

endmodule
